FILE: rtl/core/bpq_pkg.sv
// Package for the bounded priority queue: field widths, request and result
// structs, command and status codes. No dependencies.
package bpq_pkg;

	localparam int CAPACITY_DEF       = 8;
	localparam int DATA_WIDTH_DEF     = 8;
	localparam int PRIORITY_WIDTH_DEF = 4;

	localparam int DATA_FIELD_W = 8;
	localparam int PRIO_FIELD_W = 4;
	localparam int OCC_FIELD_W  = 4;
	localparam int TDATA_W      = 16;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [DATA_FIELD_W-1:0] data;
		logic [PRIO_FIELD_W-1:0] prio;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [DATA_FIELD_W-1:0] data;
		logic [OCC_FIELD_W-1:0]  occ;
	} res_t;

endpackage

FILE: rtl/core/bpq_in_stage.sv
// Input register of the bounded priority queue: holds one request until the
// result register can take its outcome. Depends on bpq_pkg.
module bpq_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 advance,
	output bpq_pkg::req_t        req_s1,
	output logic                 fire
);
	import bpq_pkg::*;

	logic valid_s1;

	assign s_axis_tready = !valid_s1 || advance;
	assign fire          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.cmd  <= cmd_t'(s_axis_tuser);
			req_s1.data <= s_axis_tdata[DATA_FIELD_W-1:0];
			req_s1.prio <= s_axis_tdata[DATA_FIELD_W+PRIO_FIELD_W-1:DATA_FIELD_W];
		end
	end

endmodule

FILE: rtl/core/bpq_store.sv
// Entry store of the bounded priority queue: a row of slots kept sorted by
// priority (oldest first among equals), with insert and head removal. Depends on bpq_pkg.
module bpq_store #(
	parameter int CAPACITY       = bpq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH     = bpq_pkg::DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = bpq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  bpq_pkg::req_t req,
	output bpq_pkg::res_t res
);
	import bpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = (DATA_WIDTH > DATA_FIELD_W) ? DATA_WIDTH : DATA_FIELD_W;
	localparam int PW = (PRIORITY_WIDTH > PRIO_FIELD_W) ? PRIORITY_WIDTH : PRIO_FIELD_W;

	logic [DATA_WIDTH-1:0]     data_q [CAPACITY];
	logic [PRIORITY_WIDTH-1:0] prio_q [CAPACITY];
	logic [CW-1:0]             count_q;

	logic [DATA_WIDTH-1:0]     data_d [CAPACITY];
	logic [PRIORITY_WIDTH-1:0] prio_d [CAPACITY];
	logic [CW-1:0]             count_d;
	logic [CAPACITY-1:0]       ge;
	logic                      write_en;

	logic [DW-1:0]             new_data_w;
	logic [PW-1:0]             new_prio_w;
	logic [DW-1:0]             head_data_w;
	logic [DATA_WIDTH-1:0]     new_data;
	logic [PRIORITY_WIDTH-1:0] new_prio;

	assign new_data_w  = DW'(req.data);
	assign new_prio_w  = PW'(req.prio);
	assign new_data    = new_data_w[DATA_WIDTH-1:0];
	assign new_prio    = new_prio_w[PRIORITY_WIDTH-1:0];
	assign head_data_w = DW'(data_q[0]);

	// The slots are sorted, so the held entries whose priority is at least the
	// new one form a run from slot zero; the new entry goes just after that run.
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			ge[k] = (CW'(k) < count_q) && (prio_q[k] >= new_prio);
		end
	end

	always_comb begin
		data_d   = data_q;
		prio_d   = prio_q;
		count_d  = count_q;
		write_en = 1'b0;
		res.status = ST_OK;
		res.data   = '0;
		if (req.cmd == CMD_ENQ) begin
			if (count_q == CW'(CAPACITY)) begin
				res.status = ST_FULL;
			end else begin
				write_en = 1'b1;
				count_d  = count_q + CW'(1);
				if (!ge[0]) begin
					data_d[0] = new_data;
					prio_d[0] = new_prio;
				end
				for (int k = 1; k < CAPACITY; k++) begin
					if (!ge[k]) begin
						if (ge[k-1]) begin
							data_d[k] = new_data;
							prio_d[k] = new_prio;
						end else begin
							data_d[k] = data_q[k-1];
							prio_d[k] = prio_q[k-1];
						end
					end
				end
			end
		end else begin
			if (count_q == '0) begin
				res.status = ST_EMPTY;
			end else begin
				write_en = 1'b1;
				count_d  = count_q - CW'(1);
				res.data = head_data_w[DATA_FIELD_W-1:0];
				for (int k = 0; k < CAPACITY - 1; k++) begin
					data_d[k] = data_q[k+1];
					prio_d[k] = prio_q[k+1];
				end
			end
		end
		res.occ = OCC_FIELD_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && write_en) begin
			data_q <= data_d;
			prio_q <= prio_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.cmd == CMD_ENQ && count_q != CW'(CAPACITY))
		|=> count_q == $past(count_q) + CW'(1))
		else $error("accepted enqueue did not add an entry");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.cmd == CMD_DEQ && count_q != '0)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue did not remove an entry");

	for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(CW'(g + 1) < count_q) |-> (prio_q[g] >= prio_q[g+1]))
			else $error("held entries out of priority order");
	end

endmodule

FILE: rtl/core/bpq_out_stage.sv
// Result register of the bounded priority queue: holds one result until the
// downstream side takes it. Depends on bpq_pkg.
module bpq_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  bpq_pkg::res_t res,
	output logic          advance,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,
	output logic [1:0]    m_axis_tuser
);
	import bpq_pkg::*;

	res_t res_q;
	logic valid_q;

	assign advance       = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(TDATA_W - DATA_FIELD_W - OCC_FIELD_W){1'b0}}, res_q.occ,
		res_q.data};
	assign m_axis_tuser  = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/core/bounded_priority_queue_top.sv
// Bounded priority queue, top level. An accepted request passes from the input register through
// the store into the result register once advance is high; its result is then offered downstream.
// Throughput: one request per cycle while advance is high (combinational sorted insert/remove).
// Reset (arst_n, asynchronous, active low) empties the queue and both registers;
// slot contents are not cleared, as a slot is only read once written.
// Depends on bpq_pkg, bpq_in_stage, bpq_store and bpq_out_stage.
module bounded_priority_queue_top #(
	parameter int CAPACITY       = bpq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH     = bpq_pkg::DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = bpq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] payload, [11:8] priority_req, [15:12] zero
	input  logic        s_axis_tuser,  // [0] command: enqueue or dequeue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] data_out, [11:8] occupancy, [15:12] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import bpq_pkg::*;

	// Request held in the input register, and the strobe that moves it through the
	// store into the result register. The store is updated in the same cycle.
	req_t req_s1;
	res_t res;
	logic fire;
	// High when the result register is free or is being emptied this cycle.
	logic advance;

	bpq_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.req_s1        (req_s1),
		.fire          (fire)
	);

	// Entries are kept sorted by descending priority, oldest first among equals,
	// so the head slot is always the one a dequeue must return.
	bpq_store #(
		.CAPACITY       (CAPACITY),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	bpq_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.res           (res),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
